### sv/cidm_pkg.sv
// Shared types, constants and the built-in watch table of the CAN ID change monitor.
// No dependencies; the other files of the block, apart from the port-level checks, refer to it by scoped names.
`default_nettype none
package cidm_pkg;

  localparam int BUILTIN_ENTRIES = 17;
  localparam int MASK_BITS       = 17;
  localparam int TIME_W          = 48;
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES      = TIME_W / DIV_BITS_PER_CYCLE;
  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [3:0] MAX_LEN = 4'd8;
  localparam logic [2:0] ADDR_MASK_REG = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DIV   = 4'b1000
  } cidm_state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic emit;
  } cidm_cmd_t;

  typedef struct packed {
    logic hit;
    logic div_idle;
  } cidm_sts_t;

  function automatic logic [10:0] watch_id(input int i);
    logic [10:0] r;
    case (i)
      0:       r = 11'h21F;
      1:       r = 11'h3E5;
      2:       r = 11'h165;
      3:       r = 11'h1A5;
      4:       r = 11'h1E0;
      5:       r = 11'h1E5;
      6:       r = 11'h3F6;
      7:       r = 11'h220;
      8:       r = 11'h221;
      9:       r = 11'h225;
      10:      r = 11'h227;
      11:      r = 11'h2A0;
      12:      r = 11'h2A1;
      13:      r = 11'h2A5;
      14:      r = 11'h261;
      15:      r = 11'h276;
      16:      r = 11'h39B;
      default: r = 11'h000;
    endcase
    return r;
  endfunction

  // Keeps the first len bytes of a payload; len is already clamped to eight.
  function automatic logic [63:0] bytes_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/cidm_div.sv
// Iterative divider by 1000 for a 48-bit microsecond value, four quotient bits a cycle.
// Depends on cidm_pkg for the bits per step, step count and divisor.
`default_nettype none
module cidm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  output logic [47:0]      quotient,
  output logic             idle
);

  logic [47:0] dvd;
  logic [9:0]  rem;
  logic [3:0]  cnt;
  logic [47:0] dvd_next;
  logic [9:0]  rem_next;

  always_comb begin
    logic [10:0] t;
    dvd_next = dvd;
    rem_next = rem;
    for (int s = 0; s < cidm_pkg::DIV_BITS_PER_CYCLE; s++) begin
      t = {rem_next, dvd_next[47]};
      if (t >= {1'b0, cidm_pkg::US_PER_MS}) begin
        t = t - {1'b0, cidm_pkg::US_PER_MS};
        dvd_next = {dvd_next[46:0], 1'b1};
      end else begin
        dvd_next = {dvd_next[46:0], 1'b0};
      end
      rem_next = t[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 4'(cidm_pkg::DIV_CYCLES);
    end else if (cnt != '0) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign quotient = dvd;
  assign idle     = (cnt == '0);

endmodule
`default_nettype wire

### sv/cidm_ctrl.sv
// Sequencing state machine of the CAN ID change monitor.
// Depends on cidm_pkg for the state, command and status types.
`default_nettype none
module cidm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire cidm_pkg::cidm_sts_t sts,
  output cidm_pkg::cidm_cmd_t      cmd,
  output logic                     busy
);

  cidm_pkg::cidm_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      cidm_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cidm_pkg::ST_MATCH;
        end
      end
      cidm_pkg::ST_MATCH: begin
        cmd.lookup = 1'b1;
        state_next = sts.hit ? cidm_pkg::ST_READ : cidm_pkg::ST_IDLE;
      end
      cidm_pkg::ST_READ: begin
        cmd.update = 1'b1;
        state_next = cidm_pkg::ST_DIV;
      end
      cidm_pkg::ST_DIV: begin
        if (sts.div_idle) begin
          cmd.emit   = 1'b1;
          state_next = cidm_pkg::ST_IDLE;
        end
      end
      default: state_next = cidm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cidm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != cidm_pkg::ST_IDLE);

endmodule
`default_nettype wire

### sv/cidm_dp.sv
// Datapath of the CAN ID change monitor: frame capture, table match, entry store and report.
// Depends on cidm_pkg and instantiates two cidm_div units.
`default_nettype none
module cidm_dp #(
  parameter int NUM_WATCHED = 17
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cidm_pkg::cidm_cmd_t cmd,
  output cidm_pkg::cidm_sts_t      sts,
  input  wire logic [16:0]         mask,
  input  wire logic [28:0]         frame_id,
  input  wire logic                is_extended,
  input  wire logic                is_remote,
  input  wire logic [3:0]          payload_length,
  input  wire logic [63:0]         payload,
  input  wire logic [47:0]         time_us,
  output logic                     result_valid,
  output logic [4:0]               entry_index,
  output logic [10:0]              matched_id,
  output logic                     changed,
  output logic [3:0]               report_length,
  output logic [63:0]              report_payload,
  output logic signed [39:0]       elapsed_ms,
  output logic [31:0]              frame_count,
  output logic [38:0]              time_ms
);

  localparam int IW = (NUM_WATCHED > 1) ? $clog2(NUM_WATCHED) : 1;

  // Captured frame.
  logic [28:0] id_q;
  logic        drop_q;
  logic [3:0]  len_q;
  logic [63:0] data_q;
  logic [47:0] now_q;
  logic [3:0]  len_clamped;

  // Entry stores.
  logic [3:0]  len_mem  [NUM_WATCHED];
  logic [63:0] pay_mem  [NUM_WATCHED];
  logic [47:0] time_mem [NUM_WATCHED];
  logic [31:0] cnt_mem  [NUM_WATCHED];
  logic [NUM_WATCHED-1:0] seen;

  logic [3:0]  rd_len;
  logic [63:0] rd_pay;
  logic [47:0] rd_time;
  logic [31:0] rd_cnt;
  logic        rd_seen;

  logic [4:0]  idx_match;
  logic        hit;
  logic [4:0]  idx_q;
  logic        changed_q;
  logic        rpt_q;
  logic        first_q;
  logic [31:0] cnt_q;
  logic [31:0] cnt_new;
  logic        chg_new;
  logic [31:0] mask_wide;
  logic [47:0] q_delta;
  logic [47:0] q_now;
  logic        idle_delta;
  logic        idle_now;

  assign len_clamped = (payload_length > cidm_pkg::MAX_LEN) ? cidm_pkg::MAX_LEN : payload_length;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q   <= frame_id;
      drop_q <= is_extended | is_remote;
      len_q  <= len_clamped;
      data_q <= payload & cidm_pkg::bytes_mask(len_clamped);
      now_q  <= time_us;
    end
  end

  always_comb begin
    idx_match = '0;
    hit       = 1'b0;
    for (int i = NUM_WATCHED - 1; i >= 0; i--) begin
      if (i < cidm_pkg::BUILTIN_ENTRIES && id_q == {18'd0, cidm_pkg::watch_id(i)}) begin
        idx_match = 5'(i);
        hit       = 1'b1;
      end
    end
  end

  assign sts.hit      = hit & ~drop_q;
  assign sts.div_idle = idle_delta & idle_now;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      idx_q   <= idx_match;
      rd_len  <= len_mem[idx_match[IW-1:0]];
      rd_pay  <= pay_mem[idx_match[IW-1:0]];
      rd_time <= time_mem[idx_match[IW-1:0]];
      rd_cnt  <= cnt_mem[idx_match[IW-1:0]];
      rd_seen <= seen[idx_match[IW-1:0]];
    end
  end

  // A never-seen entry counts from zero; the stored count is only trusted once seen.
  assign cnt_new = !rd_seen ? 32'd1 : (rd_cnt == '1) ? rd_cnt : rd_cnt + 32'd1;
  assign chg_new = !rd_seen || (rd_len != len_q) || (rd_pay != data_q);
  assign mask_wide = {15'd0, mask};

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      len_mem[idx_q[IW-1:0]]  <= len_q;
      pay_mem[idx_q[IW-1:0]]  <= data_q;
      time_mem[idx_q[IW-1:0]] <= now_q;
      cnt_mem[idx_q[IW-1:0]]  <= cnt_new;
      changed_q <= chg_new;
      rpt_q     <= chg_new | mask_wide[idx_q];
      first_q   <= ~rd_seen;
      cnt_q     <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (cmd.update) begin
      seen[idx_q[IW-1:0]] <= 1'b1;
    end
  end

  // The subtraction wraps modulo 2^48, as a free-running counter does.
  cidm_div u_div_delta (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update),
    .dividend (now_q - rd_time),
    .quotient (q_delta),
    .idle     (idle_delta)
  );

  cidm_div u_div_now (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update),
    .dividend (now_q),
    .quotient (q_now),
    .idle     (idle_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit & rpt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entry_index    <= idx_q;
      matched_id     <= id_q[10:0];
      changed        <= changed_q;
      report_length  <= len_q;
      report_payload <= data_q;
      elapsed_ms     <= first_q ? '1 : signed'(q_delta[39:0]);
      frame_count    <= cnt_q;
      time_ms        <= q_now[38:0];
    end
  end

endmodule
`default_nettype wire

### sv/can_id_change_monitor.sv
// Top level of the CAN ID change monitor: APB register, controller and datapath.
// Depends on cidm_pkg, cidm_ctrl and cidm_dp.
//
// The block takes one received CAN frame per start pulse while busy is low. Extended,
// remote and unwatched frames are dropped and hold busy only while the identifier is
// matched. A watched frame holds busy while the identifier is matched against the
// built-in table, while the entry store is read, and while the two iterative
// divide-by-1000 units (twelve steps of four quotient bits over the 48-bit time) produce
// the millisecond figures; the report is latched once both units are idle.
// A report, when the frame produces one, appears in the first cycle after busy falls,
// marked by result_valid for exactly one cycle. The receiver cannot stall the block, so
// it must take every report beat in the cycle it is shown. The report_every_mask register
// sits at byte address 0 of the APB port and should be written only while busy is low.
`default_nettype none
module can_id_change_monitor #(
  parameter int NUM_WATCHED = 17
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [28:0] frame_id,
  input  wire logic        is_extended,
  input  wire logic        is_remote,
  input  wire logic [3:0]  payload_length,
  input  wire logic [63:0] payload,
  input  wire logic [47:0] time_us,
  output logic             result_valid,
  output logic [4:0]       entry_index,
  output logic [10:0]      matched_id,
  output logic             changed,
  output logic [3:0]       report_length,
  output logic [63:0]      report_payload,
  output logic signed [39:0] elapsed_ms,
  output logic [31:0]      frame_count,
  output logic [38:0]      time_ms
);

  cidm_pkg::cidm_cmd_t cmd;
  cidm_pkg::cidm_sts_t sts;
  logic [16:0] report_every_mask;
  logic        ctrl_start;

  // The register decode looks at the word address only; byte offsets are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_every_mask <= 17'h18000;
    end else if (psel && penable && pwrite && paddr[2] == cidm_pkg::ADDR_MASK_REG[2]) begin
      report_every_mask <= pwdata[16:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cidm_pkg::ADDR_MASK_REG[2]) ? {15'd0, report_every_mask} : '0;

  // The controller only looks at start while idle, so start needs no further gating.
  assign ctrl_start = start;

  cidm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl_start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cidm_dp #(
    .NUM_WATCHED (NUM_WATCHED)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mask           (report_every_mask),
    .frame_id       (frame_id),
    .is_extended    (is_extended),
    .is_remote      (is_remote),
    .payload_length (payload_length),
    .payload        (payload),
    .time_us        (time_us),
    .result_valid   (result_valid),
    .entry_index    (entry_index),
    .matched_id     (matched_id),
    .changed        (changed),
    .report_length  (report_length),
    .report_payload (report_payload),
    .elapsed_ms     (elapsed_ms),
    .frame_count    (frame_count),
    .time_ms        (time_ms)
  );

endmodule
`default_nettype wire

### sv/cidm_checker.sv
// Port-level checks for the CAN ID change monitor, bound to its top level.
// Depends only on the ports of can_id_change_monitor.
`default_nettype none
module cidm_sva (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_valid,
  input wire logic               changed,
  input wire logic [3:0]         report_length,
  input wire logic signed [39:0] elapsed_ms,
  input wire logic [31:0]        frame_count
);

  // An accepted frame always occupies the block for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted frame did not raise busy");

  // A report is shown only after the frame's work is finished.
  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("report shown while busy");

  // First sight of an identifier is always reported as a change with count one.
  a_first_sight: assert property (@(posedge clk) disable iff (rst)
    result_valid && elapsed_ms == -40'sd1 |-> changed && frame_count == 32'd1)
    else $error("first-sight report inconsistent");

  // Reported count is never zero, and the length never exceeds eight bytes.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_count != 32'd0 && report_length <= 4'd8)
    else $error("report fields out of range");

endmodule

bind can_id_change_monitor cidm_sva u_cidm_sva (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_valid  (result_valid),
  .changed       (changed),
  .report_length (report_length),
  .elapsed_ms    (elapsed_ms),
  .frame_count   (frame_count)
);
`default_nettype wire

### dv/cidm_checker.sv
`timescale 1ns / 1ps
// Checker for the CAN ID change monitor: tracks register writes and accepted frames,
// predicts each report beat and compares it field by field. Depends on cidm_pkg.
module cidm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        start,
  input  logic        busy,
  input  logic [28:0] frame_id,
  input  logic        is_extended,
  input  logic        is_remote,
  input  logic [3:0]  payload_length,
  input  logic [63:0] payload,
  input  logic [47:0] time_us,
  input  logic        result_valid,
  input  logic [4:0]  entry_index,
  input  logic [10:0] matched_id,
  input  logic        changed,
  input  logic [3:0]  report_length,
  input  logic [63:0] report_payload,
  input  logic signed [39:0] elapsed_ms,
  input  logic [31:0] frame_count,
  input  logic [38:0] time_ms,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [4:0]  idx;
    logic [10:0] id;
    logic        chg;
    logic [3:0]  len;
    logic [63:0] data;
    logic [39:0] dms;
    logic [31:0] cnt;
    logic [38:0] tms;
  } report_t;

  localparam logic [10:0] WATCH_TABLE [17] = '{
    11'h21F, 11'h3E5, 11'h165, 11'h1A5, 11'h1E0, 11'h1E5, 11'h3F6, 11'h220, 11'h221,
    11'h225, 11'h227, 11'h2A0, 11'h2A1, 11'h2A5, 11'h261, 11'h276, 11'h39B
  };

  logic [16:0] every_mask;
  logic        seen     [17];
  logic [3:0]  prev_len [17];
  logic [63:0] prev_data[17];
  logic [47:0] prev_us  [17];
  logic [31:0] hits     [17];
  report_t     reports_due[$];

  assign pending = reports_due.size();

  // Updates the entry state for one accepted frame and queues the report it causes.
  task automatic predict_frame();
    int          idx;
    logic [3:0]  len;
    logic [63:0] data;
    logic [47:0] diff;
    logic        chg;
    report_t     r;
    idx = -1;
    if (is_extended || is_remote) return;
    for (int i = 0; i < 17; i++) begin
      if (idx < 0 && {18'd0, WATCH_TABLE[i]} == frame_id) idx = i;
    end
    if (idx < 0) return;
    len = (payload_length > 4'd8) ? 4'd8 : payload_length;
    data = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < len) data[8*b +: 8] = payload[8*b +: 8];
    end
    chg = !seen[idx] || prev_len[idx] != len || prev_data[idx] != data;
    diff = time_us - prev_us[idx];
    r.idx  = 5'(idx);
    r.id   = WATCH_TABLE[idx];
    r.chg  = chg;
    r.len  = len;
    r.data = data;
    r.dms  = seen[idx] ? 40'(diff / 48'd1000) : '1;
    r.cnt  = (hits[idx] == '1) ? hits[idx] : hits[idx] + 32'd1;
    r.tms  = 39'(time_us / 48'd1000);
    seen[idx]      = 1'b1;
    prev_len[idx]  = len;
    prev_data[idx] = data;
    prev_us[idx]   = time_us;
    hits[idx]      = r.cnt;
    if (chg || every_mask[idx]) reports_due.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    report_t e;
    if (rst) begin
      errors = 0;
      every_mask = 17'h18000;
      reports_due.delete();
      for (int i = 0; i < 17; i++) begin
        seen[i] = 1'b0;
        hits[i] = '0;
        prev_len[i] = '0;
        prev_data[i] = '0;
        prev_us[i] = '0;
      end
    end else begin
      // A report beat belongs to an earlier frame, so it is checked first.
      if (result_valid) begin
        if (reports_due.size() == 0) begin
          $error("report beat with no report expected");
          errors++;
        end else begin
          e = reports_due.pop_front();
          check_field("entry_index", e.idx, entry_index);
          check_field("matched_id", e.id, matched_id);
          check_field("changed", e.chg, changed);
          check_field("report_length", e.len, report_length);
          check_field("report_payload", e.data, report_payload);
          check_field("elapsed_ms", e.dms, elapsed_ms[39:0]);
          check_field("frame_count", e.cnt, frame_count);
          check_field("time_ms", e.tms, time_ms);
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == cidm_pkg::ADDR_MASK_REG[2])
        every_mask = pwdata[16:0];
      if (start && !busy) predict_frame();
    end
  end
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top of the CAN ID change monitor: clock, reset, frame and register stimulus.
// Depends on cidm_pkg, can_id_change_monitor and cidm_checker.
module tb;

  // A frame beat as the testbench builds it before driving it onto the ports.
  typedef struct {
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [63:0] data;
    logic [47:0] us;
  } frame_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [10:0] IDS [17] = '{
    11'h21F, 11'h3E5, 11'h165, 11'h1A5, 11'h1E0, 11'h1E5, 11'h3F6, 11'h220, 11'h221,
    11'h225, 11'h227, 11'h2A0, 11'h2A1, 11'h2A5, 11'h261, 11'h276, 11'h39B
  };

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start, busy;
  logic [28:0] frame_id;
  logic        is_extended, is_remote;
  logic [3:0]  payload_length;
  logic [63:0] payload;
  logic [47:0] time_us;
  logic        result_valid;
  logic [4:0]  entry_index;
  logic [10:0] matched_id;
  logic        changed;
  logic [3:0]  report_length;
  logic [63:0] report_payload;
  logic signed [39:0] elapsed_ms;
  logic [31:0] frame_count;
  logic [38:0] time_ms;
  int          errors, pending;
  int          idle_pct;
  int          quiet_cycles;
  logic [47:0] now_us;
  logic [63:0] last_data[17];
  logic [3:0]  last_len[17];

  can_id_change_monitor dut (.*);

  cidm_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The watchdog restarts on every accepted frame, report beat or register access.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Writes the report-every mask through the APB port: setup cycle, then access cycle.
  task automatic write_mask(logic [16:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cidm_pkg::ADDR_MASK_REG;
    pwdata  <= {15'($urandom_range(0, 32767)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every queued report has come out and the block has gone quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drives one frame beat after a random gap and holds it until the block takes it.
  // start stays high between back-to-back beats and is only lowered for a gap.
  task automatic send(frame_t f);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    frame_id       <= f.id;
    is_extended    <= f.ext;
    is_remote      <= f.rtr;
    payload_length <= f.len;
    payload        <= f.data;
    time_us        <= f.us;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic frame_t watched(int idx, logic [3:0] len, logic [63:0] data,
                                     logic [47:0] us);
    frame_t f;
    f.id   = {18'd0, IDS[idx]};
    f.ext  = 1'b0;
    f.rtr  = 1'b0;
    f.len  = len;
    f.data = data;
    f.us   = us;
    return f;
  endfunction

  // Builds one random frame. Most frames hit the watch table and often repeat the
  // entry's previous payload, so that unchanged frames and counts get exercised.
  function automatic frame_t random_frame();
    frame_t f;
    int     idx, pick;
    logic [63:0] data;
    logic [3:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 3)       now_us = 48'({$urandom(), $urandom()});
    else if (pick < 6)  now_us = now_us - 48'($urandom_range(1, 5000000));
    else                now_us = now_us + 48'($urandom_range(0, 2000000));
    idx = $urandom_range(0, 16);
    if ($urandom_range(0, 99) < 45) begin
      len  = last_len[idx];
      data = last_data[idx];
      // Noise in the bytes past the length must not count as a change.
      if ($urandom_range(0, 3) == 0 && len < 8)
        data = data | ({$urandom(), $urandom()} << (8 * len));
    end else begin
      len  = 4'($urandom_range(0, 15));
      data = {$urandom(), $urandom()};
      if ($urandom_range(0, 1) == 1)
        for (int b = 0; b < 8; b++) if (b >= len) data[8*b +: 8] = 8'h00;
      if ($urandom_range(0, 7) == 0) data[8 * $urandom_range(0, 7) +: 8] ^= 8'h01;
      last_len[idx]  = len;
      last_data[idx] = data;
    end
    f = watched(idx, len, data, now_us);
    pick = $urandom_range(0, 99);
    if (pick < 6)        f.ext = 1'b1;
    else if (pick < 12)  f.rtr = 1'b1;
    else if (pick < 16)  f.id = 29'($urandom());
    else if (pick < 19)  f.id = {18'($urandom()), IDS[idx]};
    return f;
  endfunction

  initial begin
    frame_t f;
    logic [16:0] phase_masks[3];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    frame_id = '0;
    is_extended = 1'b0;
    is_remote = 1'b0;
    payload_length = '0;
    payload = '0;
    time_us = '0;
    idle_pct = 30;
    now_us = 48'd1000000;
    for (int i = 0; i < 17; i++) begin
      last_len[i] = 4'd8;
      last_data[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no entry set to report every frame.
    write_mask(17'h0);
    send(watched(0, 4'd8, '1, 48'd1000000));          // first sight
    send(watched(0, 4'd8, '1, 48'd1002500));          // same payload, silent
    send(watched(0, 4'd4, '1, 48'd1004000));          // shorter length
    send(watched(0, 4'd4, 64'h0000_0000_FFFF_FFFF, 48'd1005000)); // tail bytes ignored
    send(watched(0, 4'd12, '1, 48'd1006000));         // length above eight
    send(watched(0, 4'd15, '1, 48'd1007000));         // same as eight, silent
    f = watched(0, 4'd8, 64'h1, 48'd1008000);
    f.ext = 1'b1;
    send(f);
    f.ext = 1'b0;
    f.rtr = 1'b1;
    send(f);
    f.rtr = 1'b0;
    f.id = 29'h1FFFF21F;
    send(f);
    f.id = '0;
    send(f);
    send(watched(16, 4'd0, '0, '1));                  // first sight at the top of time
    send(watched(16, 4'd1, 64'hA5, 48'd5));           // time wrapped around
    send(watched(1, 4'd2, 64'h1234, 48'd9000000));
    send(watched(1, 4'd2, 64'h1234, 48'd4000000));    // time going backwards, silent
    send(watched(1, 4'd2, 64'h1235, 48'd3000000));    // time going backwards, changed
    for (int i = 2; i < 16; i++) send(watched(i, 4'd1, 64'(i), 48'(i * 1000)));
    drain();

    // Random part in three phases, each under its own mask setting.
    phase_masks[0] = 17'h1FFFF;
    phase_masks[1] = 17'($urandom());
    phase_masks[2] = 17'h18000;
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 30 : (p == 1) ? 83 : 0;
      write_mask(phase_masks[p]);
      for (int n = 0; n < 460; n++) send(random_frame());
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
